// ===== hdl/afca_pkg.sv =====
// Shared types and constants for the allele frequency covariance accumulator.
// No dependencies; afca_div and the accumulator in hdl/ import this package.
`timescale 1ns / 1ps

package afca_pkg;

  localparam int ACC_W   = 48;  // accumulator and weight width
  localparam int VALUE_W = 32;  // normalized output width
  localparam int KEPT_W  = 32;  // kept-site counter width
  localparam int QUOT_W  = 33;  // divider quotient width, one bit above the output range
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POP_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAF_THRESHOLD = 2'd1;

  typedef enum logic [2:0] {
    STAT_OK             = 3'd0,
    STAT_ZERO_TOTAL     = 3'd1,
    STAT_POP_MISMATCH   = 3'd2,
    STAT_TOTAL_MISMATCH = 3'd3,
    STAT_NONE_PASSED    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FREQ,
    S_MEAN,
    S_CHECK,
    S_WMUL,
    S_WADD,
    S_OP_RD,
    S_OP_MUL,
    S_OP_WR,
    S_FIN,
    S_RD_RD,
    S_RD_LOAD,
    S_RD_DIV,
    S_RD_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ===== hdl/afca_if.sv =====
// Valid/ready channel interfaces for the count input and the readout output.
// No dependencies.
`timescale 1ns / 1ps

interface afca_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] first_count;
  logic [15:0] second_count;
  logic        end_of_site;

  modport source (output valid, operation, first_count, second_count, end_of_site,
                  input ready);
  modport sink   (input valid, operation, first_count, second_count, end_of_site,
                  output ready);
endinterface

interface afca_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row_index;
  logic [2:0]         col_num;
  logic signed [31:0] cov_value;
  logic [2:0]         status;
  logic [31:0]        kept_sites;
  logic               last;

  modport source (output valid, row_index, col_num, cov_value, status, kept_sites, last,
                  input ready);
  modport sink   (input valid, row_index, col_num, cov_value, status, kept_sites, last,
                  output ready);
endinterface

// ===== hdl/afca_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, shared by all divides.
// Depends on afca_pkg for the status struct. Dividend arrives left-aligned.
`timescale 1ns / 1ps

module afca_div
  import afca_pkg::*;
#(
  parameter int DW   = 64,
  parameter int DENW = 48,
  parameter int QW   = 33,
  parameter int CW   = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DW-1:0]   num_i,
  input  logic [CW-1:0]   nbits_i,
  input  logic [DENW-1:0] den_i,
  output logic [QW-1:0]   quot_o,
  output div_stat_t       stat_o
);

  logic [DW-1:0]   d_q;
  logic [DENW-1:0] r_q;
  logic [DENW-1:0] den_q;
  logic [QW-1:0]   q_q;
  logic            ovf_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DENW:0]   r_sh;
  logic [DENW+1:0] diff;
  logic            ge;

  assign r_sh = {r_q, d_q[DW-1]};
  assign diff = {1'b0, r_sh} - {2'b00, den_q};
  assign ge   = !diff[DENW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      d_q   <= {d_q[DW-2:0], 1'b0};
      r_q   <= ge ? diff[DENW-1:0] : r_sh[DENW-1:0];
      // sticky overflow once a set bit leaves the top of the quotient
      ovf_q <= ovf_q | q_q[QW-1];
      q_q   <= {q_q[QW-2:0], ge};
    end
  end

  assign quot_o      = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

// ===== hdl/allele_freq_covariance_accumulator.sv =====
// Allele frequency covariance accumulator: per-site frequency, filter, outer product.
// Count item: a frequency divide, plus at site end a mean divide, the filter check and,
// if it passes, the weight states (S_WMUL, S_WADD), then S_OP_RD, S_OP_MUL, S_OP_WR per
// triangle entry through the one multiplier. Finish: an error status entry, or each entry
// through the serial divider, then a clear sweep. Reset clears control state, then a sweep
// over all MAX_POPS*(MAX_POPS+1)/2 accumulator entries zeroes them; input is held off meanwhile.
`timescale 1ns / 1ps

module allele_freq_covariance_accumulator
  import afca_pkg::*;
#(
  parameter int MAX_POPS   = 8,
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  afca_in_if.sink               in_i,
  afca_out_if.source            out_o
);

  localparam int F      = FRAC_BITS;
  localparam int C      = COUNT_BITS;
  localparam int TOTW   = C + 1;
  localparam int FW     = F + 1;
  localparam int FSUM_W = FW + $clog2(MAX_POPS + 1);
  localparam int IDXW   = $clog2(MAX_POPS);
  localparam int POSW   = $clog2(MAX_POPS + 1);
  localparam int TRI    = MAX_POPS * (MAX_POPS + 1) / 2;
  localparam int KW     = $clog2(TRI);
  localparam int DW     = ACC_W + F;
  localparam int DCW    = $clog2(DW + 1);
  localparam int MULW   = F + 2;
  localparam int PW     = 2 * MULW;
  localparam int SW     = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam int CMPW   = FW + 16;

  state_e state_q, state_d;

  logic [3:0]  pop_count_q;
  logic [15:0] maf_q;

  logic [TOTW-1:0]           tot_q [MAX_POPS];
  logic [FW-1:0]             freq_mem [MAX_POPS];
  logic signed [ACC_W-1:0]   acc_mem [TRI];

  logic [ACC_W-1:0]          weight_q;
  logic [FSUM_W-1:0]         fsum_q;
  logic [KEPT_W-1:0]         kept_q;
  logic [POSW-1:0]           pos_q;
  logic                      known_q;
  status_e                   err_q, code_q;
  logic                      eos_q;
  logic [FW-1:0]             m_q;
  logic [IDXW-1:0]           i_q, j_q;
  logic [KW-1:0]             k_q;
  logic [FW-1:0]             fi_q, fj_q;
  logic signed [ACC_W-1:0]   acc_rd_q;
  logic signed [PW-1:0]      prod_q;

  logic                      out_valid_q;
  logic [2:0]                row_q, col_q;
  logic [VALUE_W-1:0]        val_q;
  status_e                   stat_q;
  logic [KEPT_W-1:0]         kept_out_q;
  logic                      last_q;

  // divider hookup
  logic              div_start;
  logic [DW-1:0]     div_num;
  logic [DCW-1:0]    div_nbits;
  logic [ACC_W-1:0]  div_den;
  logic [QUOT_W-1:0] div_quot;
  div_stat_t         div_stat;

  afca_div #(.DW(DW), .DENW(ACC_W), .QW(QUOT_W), .CW(DCW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .nbits_i (div_nbits),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // populations in use
  logic [POSW-1:0] p;
  always_comb begin
    if (pop_count_q < 4'd2) p = POSW'(2);
    else if (32'(pop_count_q) > MAX_POPS) p = POSW'(MAX_POPS);
    else p = POSW'(pop_count_q);
  end

  // input decode
  logic            in_fire;
  logic [C-1:0]    cnt_a, cnt_b;
  logic [TOTW-1:0] total;
  logic [IDXW-1:0] pos_idx;
  status_e         fin_code;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cnt_a      = C'(in_i.first_count);
  assign cnt_b      = C'(in_i.second_count);
  assign total      = TOTW'(cnt_a) + TOTW'(cnt_b);
  assign pos_idx    = pos_q[IDXW-1:0];

  always_comb begin
    if (err_q != STAT_OK) fin_code = err_q;
    else if (pos_q != '0) fin_code = STAT_POP_MISMATCH;
    else if (kept_q == '0 || weight_q == '0) fin_code = STAT_NONE_PASSED;
    else fin_code = STAT_OK;
  end

  // frequency bookkeeping
  logic [FSUM_W-1:0] fsum_nx;
  logic [POSW-1:0]   pos_nx;
  assign fsum_nx = fsum_q + FSUM_W'(div_quot[FW-1:0]);
  assign pos_nx  = pos_q + POSW'(1);

  // filter test at equal scale
  logic [FW-1:0] one_m;
  logic          pass;
  assign one_m = (FW'(1) << F) - m_q;
  assign pass  = ((CMPW'(m_q) << 16) > (CMPW'(maf_q) << F)) &&
                 ((CMPW'(one_m) << 16) > (CMPW'(maf_q) << F));

  // shared multiplier
  logic signed [MULW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]   mul_p;
  always_comb begin
    if (state_q == S_WMUL) begin
      mul_a = $signed({1'b0, m_q});
      mul_b = $signed({1'b0, one_m});
    end else begin
      mul_a = $signed({1'b0, fi_q}) - $signed({1'b0, m_q});
      mul_b = $signed({1'b0, fj_q}) - $signed({1'b0, m_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // saturating accumulate and weight update
  logic signed [SW-1:0]    acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic [SW-1:0]           w_sum;
  logic [ACC_W-1:0]        w_sat;
  assign acc_sum = SW'(acc_rd_q) + SW'(prod_q);
  always_comb begin
    if (acc_sum[SW-1:ACC_W-1] == '0 || acc_sum[SW-1:ACC_W-1] == '1) begin
      acc_sat = acc_sum[ACC_W-1:0];
    end else if (acc_sum[SW-1]) begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end
  assign w_sum = SW'(weight_q) + SW'($unsigned(prod_q));
  assign w_sat = (w_sum[SW-1:ACC_W] != '0) ? '1 : w_sum[ACC_W-1:0];

  // triangle walk
  logic            ij_last;
  logic [IDXW-1:0] i_nx, j_nx;
  assign ij_last = (POSW'(i_q) == p - POSW'(1)) && (POSW'(j_q) == p - POSW'(1));
  always_comb begin
    if (POSW'(j_q) == p - POSW'(1)) begin
      i_nx = i_q + IDXW'(1);
      j_nx = i_q + IDXW'(1);
    end else begin
      i_nx = i_q;
      j_nx = j_q + IDXW'(1);
    end
  end

  // readout value
  logic [ACC_W-1:0]   mag;
  logic [VALUE_W-1:0] norm_val;
  assign mag = acc_rd_q[ACC_W-1] ? (~acc_rd_q + ACC_W'(1)) : acc_rd_q;
  always_comb begin
    if (acc_rd_q[ACC_W-1]) begin
      if (div_stat.ovf || div_quot > (QUOT_W'(1) << (VALUE_W - 1))) begin
        norm_val = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
        norm_val = ~div_quot[VALUE_W-1:0] + VALUE_W'(1);
      end
    end else if (div_stat.ovf || div_quot[QUOT_W-1:VALUE_W-1] != '0) begin
      norm_val = {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      norm_val = div_quot[VALUE_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  // next state and strobes
  logic acc_we, acc_re, clear_run, out_load;
  logic signed [ACC_W-1:0] acc_wd;
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_nbits = '0;
    div_den   = '0;
    acc_we    = 1'b0;
    acc_wd    = '0;
    acc_re    = 1'b0;
    clear_run = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        acc_we = 1'b1;
        if (32'(k_q) == TRI - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.operation) begin
            state_d = S_FIN;
          end else if (err_q == STAT_OK && pos_q < p && total != '0 &&
                       (!known_q || tot_q[pos_idx] == total)) begin
            div_start = 1'b1;
            div_num   = DW'({cnt_a, {F{1'b0}}}) << (DW - C - F);
            div_nbits = DCW'(C + F);
            div_den   = ACC_W'(total);
            state_d   = S_FREQ;
          end
        end
      end
      S_FREQ: begin
        if (div_stat.done) begin
          if (!eos_q) begin
            state_d = S_IDLE;
          end else if (pos_nx != p) begin
            state_d = S_IDLE;
          end else begin
            div_start = 1'b1;
            div_num   = DW'(fsum_nx) << (DW - FSUM_W);
            div_nbits = DCW'(FSUM_W);
            div_den   = ACC_W'(p);
            state_d   = S_MEAN;
          end
        end
      end
      S_MEAN:   if (div_stat.done) state_d = S_CHECK;
      S_CHECK:  state_d = pass ? S_WMUL : S_IDLE;
      S_WMUL:   state_d = S_WADD;
      S_WADD:   state_d = S_OP_RD;
      S_OP_RD: begin
        acc_re  = 1'b1;
        state_d = S_OP_MUL;
      end
      S_OP_MUL: state_d = S_OP_WR;
      S_OP_WR: begin
        acc_we  = 1'b1;
        acc_wd  = acc_sat;
        state_d = ij_last ? S_IDLE : S_OP_RD;
      end
      S_FIN: begin
        if (code_q != STAT_OK) begin
          if (out_free) begin
            out_load  = 1'b1;
            clear_run = 1'b1;
            state_d   = S_CLEAR;
          end
        end else begin
          state_d = S_RD_RD;
        end
      end
      S_RD_RD: begin
        acc_re  = 1'b1;
        state_d = S_RD_LOAD;
      end
      S_RD_LOAD: begin
        div_start = 1'b1;
        div_num   = {mag, {F{1'b0}}};
        div_nbits = DCW'(DW);
        div_den   = weight_q;
        state_d   = S_RD_DIV;
      end
      S_RD_DIV: if (div_stat.done) state_d = S_RD_OUT;
      S_RD_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (ij_last) begin
            clear_run = 1'b1;
            state_d   = S_CLEAR;
          end else begin
            state_d = S_RD_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_count_q <= 4'd2;
      maf_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POP_COUNT:     pop_count_q <= cfg_data_i[3:0];
        REG_MAF_THRESHOLD: maf_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // run control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
      fsum_q   <= '0;
      kept_q   <= '0;
      pos_q    <= '0;
      known_q  <= 1'b0;
      err_q    <= STAT_OK;
      code_q   <= STAT_OK;
      eos_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else begin
      case (state_q)
        S_CLEAR: k_q <= k_q + KW'(1);
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.operation) begin
              code_q <= fin_code;
              i_q    <= '0;
              j_q    <= '0;
              k_q    <= '0;
            end else if (err_q == STAT_OK) begin
              // sticky error: drop count transfers until finish
              if (pos_q >= p) err_q <= STAT_POP_MISMATCH;
              else if (total == '0) err_q <= STAT_ZERO_TOTAL;
              else if (known_q && tot_q[pos_idx] != total) err_q <= STAT_TOTAL_MISMATCH;
              else eos_q <= in_i.end_of_site;
            end
          end
        end
        S_FREQ: begin
          if (div_stat.done) begin
            fsum_q <= fsum_nx;
            pos_q  <= pos_nx;
            if (eos_q && pos_nx != p) err_q <= STAT_POP_MISMATCH;
          end
        end
        S_CHECK: begin
          known_q <= 1'b1;
          i_q     <= '0;
          j_q     <= '0;
          k_q     <= '0;
          if (!pass) begin
            pos_q  <= '0;
            fsum_q <= '0;
          end
        end
        S_WADD: begin
          weight_q <= w_sat;
          if (kept_q != '1) kept_q <= kept_q + KEPT_W'(1);
        end
        S_OP_WR: begin
          i_q <= i_nx;
          j_q <= j_nx;
          k_q <= k_q + KW'(1);
          if (ij_last) begin
            pos_q  <= '0;
            fsum_q <= '0;
          end
        end
        S_RD_OUT: begin
          // the last entry leaves the walk to the clear below
          if (out_free && !ij_last) begin
            i_q <= i_nx;
            j_q <= j_nx;
            k_q <= k_q + KW'(1);
          end
        end
        default: ;
      endcase
      if (clear_run) begin
        weight_q <= '0;
        fsum_q   <= '0;
        kept_q   <= '0;
        pos_q    <= '0;
        known_q  <= 1'b0;
        err_q    <= STAT_OK;
        k_q      <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_fire && !in_i.operation && !known_q && pos_q < p) begin
      tot_q[pos_idx] <= total;
    end
    if (state_q == S_MEAN && div_stat.done) m_q <= div_quot[FW-1:0];
    if (state_q == S_WMUL || state_q == S_OP_MUL) prod_q <= mul_p;
  end

  // frequency store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (state_q == S_FREQ && div_stat.done) freq_mem[pos_idx] <= div_quot[FW-1:0];
    if (state_q == S_OP_RD) begin
      fi_q <= freq_mem[i_q];
      fj_q <= freq_mem[j_q];
    end
  end

  // accumulator memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[k_q] <= acc_wd;
    if (acc_re) acc_rd_q <= acc_mem[k_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kept_out_q <= kept_q;
      if (state_q == S_FIN) begin
        row_q  <= '0;
        col_q  <= '0;
        val_q  <= '0;
        stat_q <= code_q;
        last_q <= 1'b1;
      end else begin
        row_q  <= 3'(i_q);
        col_q  <= 3'(j_q);
        val_q  <= norm_val;
        stat_q <= STAT_OK;
        last_q <= ij_last;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_index  = row_q;
  assign out_o.col_num    = col_q;
  assign out_o.cov_value  = $signed(val_q);
  assign out_o.status     = stat_q;
  assign out_o.kept_sites = kept_out_q;
  assign out_o.last       = last_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stat_q != STAT_OK |-> last_q)
    else $error("error result not marked last");
  a_acc_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> 32'(k_q) < TRI)
    else $error("accumulator address out of range");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> pos_q <= p)
    else $error("site position beyond population count");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_valid_q |-> out_o.ready)
    else $error("output overwritten before transfer");
`endif

endmodule

// ===== tb/afca_checker.sv =====
// Checker for the allele frequency covariance accumulator: watches the config
// port and both channels, predicts each readout and compares. Depends on afca_pkg, afca_if.
`timescale 1ns / 1ps

module afca_checker
  import afca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  afca_in_if                    in_i,
  afca_out_if                   out_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int NPOPS = 8;
  localparam int NTRI  = NPOPS * (NPOPS + 1) / 2;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_8000_0000_0000;
  localparam longint unsigned WEIGHT_HI = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned ONE = 64'd65536;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] cov;
    status_e     status;
    logic [31:0] kept;
    logic        last;
  } cov_entry_t;

  cov_entry_t expected_entries[$];

  logic [3:0]         pop_reg;
  logic [15:0]        thr_reg;
  longint unsigned    freq[NPOPS];
  longint unsigned    totals[NPOPS];
  longint             tri_acc[NTRI];
  longint unsigned    weight;
  longint unsigned    freq_sum;
  longint unsigned    kept_sites;
  int                 pos;
  bit                 totals_known;
  status_e            err;
  int                 fails = 0;
  int                 queued = 0;

  assign fail_count_o = fails;
  assign pending_o    = queued;

  function automatic int pops_used();
    if (pop_reg < 2) return 2;
    if (pop_reg > NPOPS) return NPOPS;
    return int'(pop_reg);
  endfunction

  function automatic void clear_run();
    foreach (tri_acc[k]) tri_acc[k] = 0;
    weight       = 0;
    freq_sum     = 0;
    kept_sites   = 0;
    pos          = 0;
    totals_known = 0;
    err          = STAT_OK;
  endfunction

  // acc * 2^16 / w, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] scale_cov(longint acc, longint unsigned w);
    bit neg;
    longint unsigned a, q, r, cap;
    neg = acc < 0;
    a   = neg ? -acc : acc;
    cap = 64'd1 << 32;
    q   = a / w;
    r   = a % w;
    if (q > cap) q = cap;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= w) begin
        r = r - w;
        q = q | 1;
      end
      if (q > cap) q = cap;
    end
    if (neg) begin
      if (q > (64'd1 << 31)) q = 64'd1 << 31;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic void close_site(int p);
    longint unsigned m;
    longint di, dj, sum;
    int k;
    m = freq_sum / p;
    k = 0;
    totals_known = 1;
    if (m > thr_reg && (ONE - m) > thr_reg) begin
      for (int i = 0; i < p; i++) begin
        di = longint'(freq[i]) - longint'(m);
        for (int j = i; j < p; j++) begin
          dj  = longint'(freq[j]) - longint'(m);
          sum = tri_acc[k] + di * dj;
          tri_acc[k] = sum > ACC_HI ? ACC_HI : (sum < ACC_LO ? ACC_LO : sum);
          k++;
        end
      end
      weight = weight + m * (ONE - m);
      if (weight > WEIGHT_HI) weight = WEIGHT_HI;
      if (kept_sites < 64'hFFFF_FFFF) kept_sites++;
    end
    pos      = 0;
    freq_sum = 0;
  endfunction

  function automatic void take_counts(logic [15:0] a, logic [15:0] b, logic eos);
    longint unsigned total;
    int p;
    p     = pops_used();
    total = longint'(a) + longint'(b);
    if (err != STAT_OK) return;
    if (pos >= p) begin
      err = STAT_POP_MISMATCH;
      return;
    end
    if (total == 0) begin
      err = STAT_ZERO_TOTAL;
      return;
    end
    if (!totals_known) totals[pos] = total;
    else if (totals[pos] != total) begin
      err = STAT_TOTAL_MISMATCH;
      return;
    end
    freq[pos] = (longint'(a) << 16) / total;
    freq_sum  = freq_sum + freq[pos];
    pos++;
    if (eos) begin
      if (pos != p) begin
        err = STAT_POP_MISMATCH;
        return;
      end
      close_site(p);
    end
  endfunction

  function automatic void take_finish();
    cov_entry_t e;
    status_e code;
    int p, k, n;
    p    = pops_used();
    code = err;
    if (code == STAT_OK && pos != 0) code = STAT_POP_MISMATCH;
    if (code == STAT_OK && (kept_sites == 0 || weight == 0)) code = STAT_NONE_PASSED;
    if (code != STAT_OK) begin
      e = '{3'd0, 3'd0, 32'd0, code, kept_sites[31:0], 1'b1};
      expected_entries.insert(expected_entries.size(), e);
    end else begin
      k = 0;
      n = p * (p + 1) / 2;
      for (int i = 0; i < p; i++) begin
        for (int j = i; j < p; j++) begin
          e = '{3'(i), 3'(j), scale_cov(tri_acc[k], weight), STAT_OK, kept_sites[31:0],
                k + 1 == n};
          expected_entries.insert(expected_entries.size(), e);
          k++;
        end
      end
    end
    clear_run();
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] readout error: %s", $realtime, what);
    fails++;
  endtask

  function automatic void set_defaults();
    pop_reg = 4'd2;
    thr_reg = 16'd0;
    clear_run();
    expected_entries.delete();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cov_entry_t e;
    if (!rst_ni) begin
      set_defaults();
    end else begin
      // compare readout first: it belongs to items accepted earlier
      if (out_i.valid && out_i.ready) begin
        if (expected_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer row %0d col %0d",
                                    out_i.row_index, out_i.col_num));
        end else begin
          e = expected_entries.pop_front();
          if (out_i.row_index !== e.row)
            report_mismatch($sformatf("row_index %0d, want %0d", out_i.row_index, e.row));
          if (out_i.col_num !== e.col)
            report_mismatch($sformatf("column %0d, want %0d", out_i.col_num, e.col));
          if (out_i.cov_value !== e.cov)
            report_mismatch($sformatf("cov_value %0d, want %0d (row %0d col %0d)",
                                      out_i.cov_value, $signed(e.cov), e.row, e.col));
          if (out_i.status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", out_i.status, e.status));
          if (out_i.kept_sites !== e.kept)
            report_mismatch($sformatf("kept_sites %0d, want %0d", out_i.kept_sites, e.kept));
          if (out_i.last !== e.last)
            report_mismatch($sformatf("last %0b, want %0b", out_i.last, e.last));
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.operation) take_finish();
        else take_counts(in_i.first_count, in_i.second_count, in_i.end_of_site);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_POP_COUNT) pop_reg = cfg_data_i[3:0];
        else if (cfg_idx_i == REG_MAF_THRESHOLD) thr_reg = cfg_data_i;
      end
    end
    queued = expected_entries.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the allele frequency covariance accumulator: clock, reset,
// stimulus and verdict. Depends on afca_pkg, afca_if and afca_checker.
`timescale 1ns / 1ps

module tb_top;
  import afca_pkg::*;

  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT   = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    idle_pct;
  int                    stall_pct;
  int                    pops;
  int                    items_sent;
  int                    quiet_cycles = 0;
  logic [16:0]           site_totals[8];

  afca_in_if  in_if();
  afca_out_if out_if();

  allele_freq_covariance_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  afca_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("allele_freq_covariance_accumulator: mismatch");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [15:0] a, logic [15:0] b, logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.first_count  <= a;
    in_if.second_count <= b;
    in_if.end_of_site  <= eos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
  endtask

  // hold input until every readout is back and the block has gone quiet
  task automatic drain();
    drop_valid();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_pops(int value);
    write_reg(REG_POP_COUNT, 16'(value));
    pops = value < 2 ? 2 : (value > 8 ? 8 : value);
  endtask

  task automatic pick_totals(bit extreme);
    foreach (site_totals[i])
      site_totals[i] = extreme ? 17'd65535 :
                       ($urandom_range(3) == 0 ? 17'($urandom_range(1, 40))
                                               : 17'($urandom_range(1, 65535)));
  endtask

  task automatic send_site();
    logic [16:0] a;
    for (int i = 0; i < pops; i++) begin
      case ($urandom_range(7))
        0:       a = 17'd0;
        1:       a = site_totals[i];
        default: a = 17'($urandom_range(0, site_totals[i]));
      endcase
      send_item(1'b0, a[15:0], 16'(site_totals[i] - a), i == pops - 1);
    end
  endtask

  task automatic send_finish();
    send_item(1'b1, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // one run: well-formed sites, sometimes broken somewhere, then a finish
  task automatic random_run();
    int nsites, broken;
    logic [16:0] a;
    nsites = $urandom_range(1, 5);
    broken = $urandom_range(9);
    pick_totals($urandom_range(9) == 0);
    for (int s = 0; s < nsites; s++) send_site();
    case (broken)
      0: send_item(1'b0, 16'd0, 16'd0, 1'($urandom));
      1: begin
        a = site_totals[0] == 17'd1 ? 17'd2 : site_totals[0] - 17'd1;
        send_item(1'b0, 16'($urandom_range(0, a)), 16'd0, 1'b0);
        send_item(1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
      end
      2: send_item(1'b0, 16'($urandom_range(0, site_totals[0])), 16'd0, 1'b1);
      3: begin
        a = 17'($urandom_range(0, site_totals[0]));
        send_item(1'b0, a[15:0], 16'(site_totals[0] - a), 1'b0);
      end
      default: ;
    endcase
    send_finish();
  endtask

  initial begin
    int phase_goal;
    in_if.valid        = 1'b0;
    in_if.operation    = 1'b0;
    in_if.first_count  = '0;
    in_if.second_count = '0;
    in_if.end_of_site  = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_POP_COUNT;
    cfg_data           = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    items_sent         = 0;
    pops               = 2;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: two populations, no filter
    set_pops(2);
    write_reg(REG_MAF_THRESHOLD, 16'd0);
    send_item(1'b0, 16'hFFFF, 16'h0000, 1'b0);
    send_item(1'b0, 16'h0000, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'h0000, 16'hFFFF, 1'b0);
    send_item(1'b0, 16'hFFFF, 16'h0000, 1'b1);
    send_finish();
    send_finish();                                    // nothing passed
    send_item(1'b0, 16'd0, 16'd0, 1'b0);              // zero total, then ignored item
    send_item(1'b0, 16'd5, 16'd5, 1'b1);
    send_finish();
    send_item(1'b0, 16'd3, 16'd4, 1'b1);              // end marker too early
    send_finish();
    send_item(1'b0, 16'd3, 16'd4, 1'b0);
    send_item(1'b0, 16'd1, 16'd1, 1'b0);
    send_item(1'b0, 16'd1, 16'd1, 1'b0);              // third population of two
    send_finish();
    send_item(1'b0, 16'd1, 16'd2, 1'b0);
    send_item(1'b0, 16'd2, 16'd1, 1'b1);
    send_item(1'b0, 16'd1, 16'd1, 1'b0);              // total changed
    send_finish();
    send_item(1'b0, 16'd1, 16'd2, 1'b0);              // partial site at finish
    send_finish();
    drain();
    write_reg(REG_MAF_THRESHOLD, 16'hFFFF);           // nothing can pass
    send_item(1'b0, 16'd1, 16'd3, 1'b0);
    send_item(1'b0, 16'd3, 16'd1, 1'b1);
    send_finish();
    drain();
    set_pops(15);                                     // clamps to eight
    write_reg(REG_MAF_THRESHOLD, 16'd0);
    pick_totals(1'b1);
    send_site();
    send_site();
    send_finish();

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      idle_pct  = phase == 1 || phase == 3 ? 78 : (phase == 3 ? 36 : 0);
      stall_pct = phase == 2 || phase == 3 ? 78 : 0;
      if (phase == 3) begin
        idle_pct  = 36;
        stall_pct = 36;
      end
      case (phase)
        0: set_pops(8);
        1: set_pops(0);
        default: set_pops($urandom_range(15));
      endcase
      write_reg(REG_MAF_THRESHOLD, phase == 0 ? 16'd0 : 16'($urandom_range(0, 20000)));
      phase_goal = items_sent + 25;
      while (items_sent < phase_goal) begin
        random_run();
        if ($urandom_range(3) == 0) drain();
      end
    end

    drain();
    if (fail_count == 0) $display("allele_freq_covariance_accumulator: match");
    else $display("allele_freq_covariance_accumulator: mismatch");
    $finish;
  end

endmodule
